@@ hw/rtl/hbs_pkg.sv @@
// Shared constants and types for the height-map bilinear sampler.
// Used by every RTL file of the block except hbs_ram; depends on nothing.
`default_nettype none

package hbs_pkg;

	localparam int MAX_WIDTH   = 256;
	localparam int MAX_HEIGHT  = 256;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int WD_W        = $clog2(MAX_WIDTH + 1);
	localparam int HD_W        = $clog2(MAX_HEIGHT + 1);
	localparam int XI_W        = $clog2(MAX_WIDTH);
	localparam int ZI_W        = $clog2(MAX_HEIGHT);

	localparam int SAMPLE_W    = 8;
	localparam int FRAC_W      = 16;
	localparam int NBR         = 4;
	localparam int IN_DATA_W   = 152;
	localparam int OUT_DATA_W  = 40;

	localparam int REG_COUNT   = 7;
	localparam int REG_IDX_W   = $clog2(REG_COUNT);
	localparam int APB_ADDR_W  = REG_IDX_W + 2;

	localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH    = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT   = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_INV_STEP      = REG_IDX_W'(2);
	localparam logic [REG_IDX_W-1:0] REG_CENTER_X      = REG_IDX_W'(3);
	localparam logic [REG_IDX_W-1:0] REG_CENTER_Z      = REG_IDX_W'(4);
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT_SCALE  = REG_IDX_W'(5);
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT_OFFSET = REG_IDX_W'(6);

	localparam logic [8:0]  RST_GRID_WIDTH    = 9'd2;
	localparam logic [8:0]  RST_GRID_HEIGHT   = 9'd2;
	localparam logic [31:0] RST_INV_STEP      = 32'd65536;
	localparam logic [31:0] RST_CENTER_X      = 32'd0;
	localparam logic [31:0] RST_CENTER_Z      = 32'd0;
	localparam logic [31:0] RST_HEIGHT_SCALE  = 32'd257;
	localparam logic [31:0] RST_HEIGHT_OFFSET = 32'd0;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef struct packed {
		logic                     vld;
		logic                     qry;
		logic [FRAC_W-1:0]        xf;
		logic [FRAC_W-1:0]        zf;
		logic signed [32:0]       lim;
	} side_t;

	typedef struct packed {
		logic                     en;
		logic [ADDR_W-1:0]        addr;
		logic [SAMPLE_W-1:0]      data;
	} wr_t;

endpackage

`default_nettype wire

@@ hw/rtl/hbs_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read.
// Stands alone; no package needed.
`default_nettype none

module hbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/hbs_addr.sv @@
// Front of the sampler pipeline: offset, reciprocal multiply, clamp and address.
// Produces the four tap addresses and the load write for the sample store; uses hbs_pkg.
`default_nettype none

module hbs_addr (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           adv,
	input  logic                                           in_acc,
	input  logic [0:0]                                     in_user,
	input  logic [hbs_pkg::IN_DATA_W-1:0]                  in_data,
	input  logic [8:0]                                     grid_width,
	input  logic [8:0]                                     grid_height,
	input  logic [31:0]                                    inv_step,
	input  logic signed [31:0]                             center_x,
	input  logic signed [31:0]                             center_z,
	output hbs_pkg::side_t                                 side_s4,
	output hbs_pkg::wr_t                                   wr_s4,
	output logic [hbs_pkg::NBR-1:0][hbs_pkg::ADDR_W-1:0]   raddr_s4
);

	logic                            vld_s1, vld_s2, vld_s3, vld_s4;
	logic                            qry_s1, qry_s2, qry_s3, qry_s4;
	logic                            ldok_s1, ldok_s2, ldok_s3, ldok_s4;
	logic [15:0]                     idx_s1, idx_s2, idx_s3;
	logic [hbs_pkg::SAMPLE_W-1:0]    smp_s1, smp_s2, smp_s3, smp_s4;
	logic [hbs_pkg::ADDR_W-1:0]      wa_s4;
	logic signed [32:0]              lim_s1, lim_s2, lim_s3, lim_s4;
	logic signed [32:0]              gx_s1, gz_s1;
	logic [63:0]                     px_s2, pz_s2;
	logic                            npx_s2, npz_s2;
	logic [hbs_pkg::XI_W-1:0]        xi_s3;
	logic [hbs_pkg::ZI_W-1:0]        zi_s3;
	logic [hbs_pkg::FRAC_W-1:0]      xf_s3, zf_s3, xf_s4, zf_s4;

	logic [hbs_pkg::WD_W-1:0]        w_eff;
	logic [hbs_pkg::HD_W-1:0]        h_eff;
	logic [hbs_pkg::XI_W-1:0]        x_lim, xi_c;
	logic [hbs_pkg::ZI_W-1:0]        z_lim, zi_c;
	logic [hbs_pkg::FRAC_W-1:0]      xf_c, zf_c;
	logic [hbs_pkg::ADDR_W-1:0]      base_c, w_a;

	always_comb begin
		if (grid_width < 9'd2) begin
			w_eff = hbs_pkg::WD_W'(2);
		end else if (32'(grid_width) > 32'(hbs_pkg::MAX_WIDTH)) begin
			w_eff = hbs_pkg::WD_W'(hbs_pkg::MAX_WIDTH);
		end else begin
			w_eff = hbs_pkg::WD_W'(grid_width);
		end
		if (grid_height < 9'd2) begin
			h_eff = hbs_pkg::HD_W'(2);
		end else if (32'(grid_height) > 32'(hbs_pkg::MAX_HEIGHT)) begin
			h_eff = hbs_pkg::HD_W'(hbs_pkg::MAX_HEIGHT);
		end else begin
			h_eff = hbs_pkg::HD_W'(grid_height);
		end
	end

	assign x_lim = hbs_pkg::XI_W'(w_eff - hbs_pkg::WD_W'(2));
	assign z_lim = hbs_pkg::ZI_W'(h_eff - hbs_pkg::HD_W'(2));

	// A coordinate at or below zero maps to the first cell; one at the start of the last
	// usable cell or beyond it is pinned there with no fraction.
	always_comb begin
		xi_c = '0;
		xf_c = '0;
		if (!npx_s2) begin
			if (px_s2[63:32] >= 32'(x_lim)) begin
				xi_c = x_lim;
			end else begin
				xi_c = px_s2[32 +: hbs_pkg::XI_W];
				xf_c = px_s2[31:16];
			end
		end
		zi_c = '0;
		zf_c = '0;
		if (!npz_s2) begin
			if (pz_s2[63:32] >= 32'(z_lim)) begin
				zi_c = z_lim;
			end else begin
				zi_c = pz_s2[32 +: hbs_pkg::ZI_W];
				zf_c = pz_s2[31:16];
			end
		end
	end

	assign w_a    = hbs_pkg::ADDR_W'(w_eff);
	assign base_c = hbs_pkg::ADDR_W'(hbs_pkg::ADDR_W'(zi_s3) * w_a) + hbs_pkg::ADDR_W'(xi_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_acc;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			qry_s1  <= in_user[0];
			idx_s1  <= in_data[15:0];
			smp_s1  <= in_data[23:16];
			ldok_s1 <= 32'(in_data[15:0]) < 32'(hbs_pkg::STORE_DEPTH);
			gx_s1   <= 33'($signed(in_data[55:24])) + 33'(center_x);
			gz_s1   <= 33'($signed(in_data[119:88])) + 33'(center_z);
			lim_s1  <= 33'($signed(in_data[87:56])) - 33'($signed(in_data[151:120]));

			qry_s2  <= qry_s1;
			idx_s2  <= idx_s1;
			smp_s2  <= smp_s1;
			ldok_s2 <= ldok_s1;
			lim_s2  <= lim_s1;
			px_s2   <= 64'(gx_s1[31:0]) * 64'(inv_step);
			pz_s2   <= 64'(gz_s1[31:0]) * 64'(inv_step);
			npx_s2  <= gx_s1[32] || (gx_s1 == '0);
			npz_s2  <= gz_s1[32] || (gz_s1 == '0);

			qry_s3  <= qry_s2;
			idx_s3  <= idx_s2;
			smp_s3  <= smp_s2;
			ldok_s3 <= ldok_s2;
			lim_s3  <= lim_s2;
			xi_s3   <= xi_c;
			xf_s3   <= xf_c;
			zi_s3   <= zi_c;
			zf_s3   <= zf_c;

			qry_s4  <= qry_s3;
			ldok_s4 <= ldok_s3;
			smp_s4  <= smp_s3;
			wa_s4   <= hbs_pkg::ADDR_W'(idx_s3);
			lim_s4  <= lim_s3;
			xf_s4   <= xf_s3;
			zf_s4   <= zf_s3;
			raddr_s4[0] <= base_c;
			raddr_s4[1] <= base_c + w_a;
			raddr_s4[2] <= base_c + hbs_pkg::ADDR_W'(1);
			raddr_s4[3] <= base_c + w_a + hbs_pkg::ADDR_W'(1);
		end
	end

	assign side_s4 = '{vld: vld_s4, qry: qry_s4, xf: xf_s4, zf: zf_s4, lim: lim_s4};
	assign wr_s4   = '{en: vld_s4 && (qry_s4 == hbs_pkg::ACT_LOAD) && ldok_s4,
		addr: wa_s4, data: smp_s4};

endmodule

`default_nettype wire

@@ hw/rtl/hbs_interp.sv @@
// Back of the sampler pipeline: bilinear blend, scaling, offset and collision test.
// Takes the four registered store words and the side data; uses hbs_pkg.
`default_nettype none

module hbs_interp (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           adv,
	input  logic [hbs_pkg::NBR-1:0][hbs_pkg::SAMPLE_W-1:0] rdata,
	input  hbs_pkg::side_t                                 side_s4,
	input  logic [31:0]                                    height_scale,
	input  logic signed [31:0]                             height_offset,
	output logic                                           out_vld,
	output logic signed [31:0]                             out_height,
	output logic                                           out_coll
);

	logic                          qv_s5, qv_s6, qv_s7, qv_s8, qv_s9, out_vld_q;
	logic [hbs_pkg::FRAC_W-1:0]    xf_s5, zf_s5, zf_s6;
	logic signed [32:0]            lim_s5, lim_s6, lim_s7, lim_s8, lim_s9;
	logic [23:0]                   bot_s6, top_s6, mixed_s7;
	logic [39:0]                   scaled_s8;
	logic signed [31:0]            hgt_s9, hgt_q;
	logic                          coll_q;

	logic signed [25:0]            xfe, s0e, s1e, dxb, dxt, bot_c, top_c;
	logic signed [41:0]            bote, dte, zfe, mix_c;
	logic [55:0]                   scl_c;
	logic signed [41:0]            hsum_c;
	logic signed [31:0]            hgt_c;

	// Row blends: a + (b - a) * f, which equals a*(1-f) + b*f exactly.
	assign xfe   = 26'($signed({1'b0, xf_s5}));
	assign s0e   = 26'($signed({1'b0, rdata[0]}));
	assign s1e   = 26'($signed({1'b0, rdata[1]}));
	assign dxb   = 26'($signed({1'b0, rdata[2]})) - s0e;
	assign dxt   = 26'($signed({1'b0, rdata[3]})) - s1e;
	assign bot_c = (s0e <<< 16) + dxb * xfe;
	assign top_c = (s1e <<< 16) + dxt * xfe;

	assign bote  = 42'($signed({1'b0, bot_s6}));
	assign dte   = 42'($signed({1'b0, top_s6})) - bote;
	assign zfe   = 42'($signed({1'b0, zf_s6}));
	assign mix_c = (bote <<< 16) + dte * zfe + 42'sd32768;

	assign scl_c = 56'(mixed_s7) * 56'(height_scale) + 56'd32768;

	// The scaled value is never negative, so only the upper bound can be crossed.
	assign hsum_c = 42'($signed({1'b0, scaled_s8})) + 42'(height_offset);
	assign hgt_c  = (hsum_c > 42'sd2147483647) ? 32'sh7FFF_FFFF : hsum_c[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_s5     <= 1'b0;
			qv_s6     <= 1'b0;
			qv_s7     <= 1'b0;
			qv_s8     <= 1'b0;
			qv_s9     <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			qv_s5     <= side_s4.vld && (side_s4.qry == hbs_pkg::ACT_QUERY);
			qv_s6     <= qv_s5;
			qv_s7     <= qv_s6;
			qv_s8     <= qv_s7;
			qv_s9     <= qv_s8;
			out_vld_q <= qv_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xf_s5     <= side_s4.xf;
			zf_s5     <= side_s4.zf;
			lim_s5    <= side_s4.lim;

			bot_s6    <= bot_c[23:0];
			top_s6    <= top_c[23:0];
			zf_s6     <= zf_s5;
			lim_s6    <= lim_s5;

			mixed_s7  <= mix_c[39:16];
			lim_s7    <= lim_s6;

			scaled_s8 <= scl_c[55:16];
			lim_s8    <= lim_s7;

			hgt_s9    <= hgt_c;
			lim_s9    <= lim_s8;

			hgt_q     <= hgt_s9;
			coll_q    <= 33'(hgt_s9) > lim_s9;
		end
	end

	assign out_vld    = out_vld_q;
	assign out_height = hgt_q;
	assign out_coll   = coll_q;

endmodule

`default_nettype wire

@@ hw/rtl/heightmap_bilinear_sampler_top.sv @@
// Top level of the height-map bilinear sampler: register file, four store copies, pipeline.
// Depends on hbs_pkg, hbs_ram, hbs_addr and hbs_interp.
//
// The slave stream carries one word per accepted item. tuser selects the kind:
// a load writes one 8-bit sample at sample_index and returns nothing; a query
// returns one master word with the interpolated height and the collision flag.
// The sample store is held four times over, each copy written by every load,
// so that the four neighbours of a query are read in the same cycle.
// Throughput is one word per cycle, loads and queries alike, while the pipeline
// is not held. The two 32-bit multiplies share a stage; the store read, the row
// blends, the column blend and the scaling each take a stage of their own.
// Loads write the store at the same stage where queries read it, so every query
// sees exactly the loads accepted before it.
// When the result register is full and the receiver stalls, the whole
// pipeline holds and s_tready falls in the same cycle.
// Reset sets the configuration registers to their defaults and empties the pipeline; the
// store is not cleared, and a sample must be loaded before a query reads it. The user must
// write configuration through the APB port while idle; the block does not enforce this.
`default_nettype none

module heightmap_bilinear_sampler_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// sample_index[15:0], sample[23:16], pos_x[55:24], pos_y[87:56],
	// pos_z[119:88], margin[151:120]
	input  logic [hbs_pkg::IN_DATA_W-1:0]        s_tdata,
	// action[0]
	input  logic [0:0]                           s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// surface_height[31:0], collides[32], zero[39:33]
	output logic [hbs_pkg::OUT_DATA_W-1:0]       m_tdata,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [hbs_pkg::APB_ADDR_W-1:0]       paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready
);

	logic [8:0]                                  grid_width_q, grid_height_q;
	logic [31:0]                                 inv_step_q, height_scale_q;
	logic signed [31:0]                          center_x_q, center_z_q, height_offset_q;
	logic [hbs_pkg::REG_IDX_W-1:0]               reg_idx;
	logic                                        cfg_wr;

	logic                                        adv, in_acc, ram_we;
	hbs_pkg::side_t                              side_s4;
	hbs_pkg::wr_t                                wr_s4;
	logic [hbs_pkg::NBR-1:0][hbs_pkg::ADDR_W-1:0] raddr_s4;
	logic [hbs_pkg::NBR-1:0][hbs_pkg::SAMPLE_W-1:0] rdata;
	logic                                        out_vld, out_coll;
	logic signed [31:0]                          out_height;

	assign pready  = 1'b1;
	assign reg_idx = paddr[hbs_pkg::APB_ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q    <= hbs_pkg::RST_GRID_WIDTH;
			grid_height_q   <= hbs_pkg::RST_GRID_HEIGHT;
			inv_step_q      <= hbs_pkg::RST_INV_STEP;
			center_x_q      <= hbs_pkg::RST_CENTER_X;
			center_z_q      <= hbs_pkg::RST_CENTER_Z;
			height_scale_q  <= hbs_pkg::RST_HEIGHT_SCALE;
			height_offset_q <= hbs_pkg::RST_HEIGHT_OFFSET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				hbs_pkg::REG_GRID_WIDTH:    grid_width_q    <= pwdata[8:0];
				hbs_pkg::REG_GRID_HEIGHT:   grid_height_q   <= pwdata[8:0];
				hbs_pkg::REG_INV_STEP:      inv_step_q      <= pwdata;
				hbs_pkg::REG_CENTER_X:      center_x_q      <= pwdata;
				hbs_pkg::REG_CENTER_Z:      center_z_q      <= pwdata;
				hbs_pkg::REG_HEIGHT_SCALE:  height_scale_q  <= pwdata;
				hbs_pkg::REG_HEIGHT_OFFSET: height_offset_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			hbs_pkg::REG_GRID_WIDTH:    prdata = 32'(grid_width_q);
			hbs_pkg::REG_GRID_HEIGHT:   prdata = 32'(grid_height_q);
			hbs_pkg::REG_INV_STEP:      prdata = inv_step_q;
			hbs_pkg::REG_CENTER_X:      prdata = center_x_q;
			hbs_pkg::REG_CENTER_Z:      prdata = center_z_q;
			hbs_pkg::REG_HEIGHT_SCALE:  prdata = height_scale_q;
			hbs_pkg::REG_HEIGHT_OFFSET: prdata = height_offset_q;
			default:                    prdata = '0;
		endcase
	end

	assign adv      = !out_vld || m_tready;
	assign s_tready = adv;
	assign in_acc   = s_tvalid && adv;
	assign ram_we   = adv && wr_s4.en;

	hbs_addr u_addr (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.in_acc      (in_acc),
		.in_user     (s_tuser),
		.in_data     (s_tdata),
		.grid_width  (grid_width_q),
		.grid_height (grid_height_q),
		.inv_step    (inv_step_q),
		.center_x    (center_x_q),
		.center_z    (center_z_q),
		.side_s4     (side_s4),
		.wr_s4       (wr_s4),
		.raddr_s4    (raddr_s4)
	);

	for (genvar g = 0; g < hbs_pkg::NBR; g++) begin : g_copy
		hbs_ram #(
			.WIDTH (hbs_pkg::SAMPLE_W),
			.DEPTH (hbs_pkg::STORE_DEPTH)
		) u_ram (
			.clk   (clk),
			.we    (ram_we),
			.waddr (wr_s4.addr),
			.wdata (wr_s4.data),
			.re    (adv),
			.raddr (raddr_s4[g]),
			.rdata (rdata[g])
		);
	end

	hbs_interp u_interp (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.rdata         (rdata),
		.side_s4       (side_s4),
		.height_scale  (height_scale_q),
		.height_offset (height_offset_q),
		.out_vld       (out_vld),
		.out_height    (out_height),
		.out_coll      (out_coll)
	);

	assign m_tvalid = out_vld;
	assign m_tdata  = {7'b0, out_coll, out_height};

	// A load and a query never share the store stage, so writes cannot race reads.
	a_write_not_query: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !(side_s4.vld && (side_s4.qry == hbs_pkg::ACT_QUERY)))
		else $error("store write issued while a query holds the store stage");

	// The clamped cell always has four distinct neighbours inside the store.
	a_taps_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		(side_s4.vld && (side_s4.qry == hbs_pkg::ACT_QUERY)) |->
		((raddr_s4[1] != raddr_s4[0]) && (raddr_s4[2] != raddr_s4[0]) &&
		(raddr_s4[3] != raddr_s4[1]) && (raddr_s4[3] != raddr_s4[2])))
		else $error("query tap addresses collide");

	// A result can newly appear only if the pipeline was not stalled in the cycle before.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(adv))
		else $error("result appeared while the pipeline was stalled");

endmodule

`default_nettype wire
